// File: sv/pdta_pkg.sv
// ----------------------------------------------------------------------------
// pdta_pkg
// Shared widths and types for the point distance / triangle area block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package pdta_pkg;
   localparam int COORD_W  = 16;
   localparam int DIFF_W   = COORD_W + 1;
   localparam int PROD_W   = 2 * DIFF_W;
   localparam int MAG_W    = PROD_W;
   localparam int HALF_W   = MAG_W / 2;
   localparam int SQ_W     = 2 * MAG_W;
   localparam int SUM_W    = SQ_W + 2;
   localparam int SHIFT    = 18;
   localparam int RAD_W    = SUM_W - SHIFT;
   localparam int ROOT_W   = RAD_W / 2;
   localparam int REM_W    = ROOT_W + 2;
   localparam int RESULT_W = 25;
   localparam int N_CELLS  = ROOT_W;

   localparam logic OP_DISTANCE = 1'b0;
   localparam logic OP_AREA     = 1'b1;

   typedef struct packed {
      logic              valid;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      logic [RAD_W-1:0]  rad;
   } sqrt_cell_type;
endpackage
`default_nettype wire

// File: sv/pdta_front.sv
// ----------------------------------------------------------------------------
// pdta_front
// Differences, cross product and squared magnitude, six pipeline stages
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pdta_front (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               en,
   input  wire logic                               in_valid,
   input  wire logic                               op,
   input  wire logic signed [pdta_pkg::COORD_W-1:0] first_x,
   input  wire logic signed [pdta_pkg::COORD_W-1:0] first_y,
   input  wire logic signed [pdta_pkg::COORD_W-1:0] first_z,
   input  wire logic signed [pdta_pkg::COORD_W-1:0] second_x,
   input  wire logic signed [pdta_pkg::COORD_W-1:0] second_y,
   input  wire logic signed [pdta_pkg::COORD_W-1:0] second_z,
   input  wire logic signed [pdta_pkg::COORD_W-1:0] third_x,
   input  wire logic signed [pdta_pkg::COORD_W-1:0] third_y,
   input  wire logic signed [pdta_pkg::COORD_W-1:0] third_z,
   output pdta_pkg::sqrt_cell_type                 cell_out
);
   localparam int DW = pdta_pkg::DIFF_W;
   localparam int PW = pdta_pkg::PROD_W;
   localparam int MW = pdta_pkg::MAG_W;
   localparam int HW = pdta_pkg::HALF_W;

   logic [5:0] valid_ff, valid_in;
   logic [4:0] op_ff;

   logic signed [DW-1:0] ux_ff, uy_ff, uz_ff, vx_ff, vy_ff, vz_ff;
   logic signed [PW-1:0] pa_ff, pb_ff, pc_ff, pd_ff, pe_ff, pf_ff;
   logic signed [PW-1:0] dx_ff, dy_ff, dz_ff;
   logic signed [PW:0]   kx_in, ky_in, kz_in;
   logic [2:0][MW-1:0]   mag_ff, mag_in;
   logic [MW-1:0]        dsum3_ff, dsum4_ff, dsum5_ff;
   logic [2:0][MW-1:0]   hh_ff, hl_ff, ll_ff;
   logic [2:0][pdta_pkg::SQ_W-1:0] sq_ff;
   logic [pdta_pkg::SUM_W-1:0] sum_in;
   logic [pdta_pkg::RAD_W-1:0] rad_ff, rad_in;

   assign valid_in = {valid_ff[4:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   assign kx_in = {pa_ff[PW-1], pa_ff} - {pb_ff[PW-1], pb_ff};
   assign ky_in = {pc_ff[PW-1], pc_ff} - {pd_ff[PW-1], pd_ff};
   assign kz_in = {pe_ff[PW-1], pe_ff} - {pf_ff[PW-1], pf_ff};

   always_comb begin
      mag_in[0] = kx_in[PW] ? MW'(-kx_in) : MW'(kx_in);
      mag_in[1] = ky_in[PW] ? MW'(-ky_in) : MW'(ky_in);
      mag_in[2] = kz_in[PW] ? MW'(-kz_in) : MW'(kz_in);
   end

   assign sum_in = pdta_pkg::SUM_W'(sq_ff[0]) + pdta_pkg::SUM_W'(sq_ff[1])
                 + pdta_pkg::SUM_W'(sq_ff[2]);
   assign rad_in = (op_ff[4] == pdta_pkg::OP_AREA) ?
                   sum_in[pdta_pkg::SUM_W-1:pdta_pkg::SHIFT] :
                   pdta_pkg::RAD_W'(dsum5_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         op_ff <= {op_ff[3:0], op};
         // stage 1: edge vectors
         ux_ff <= DW'(second_x) - DW'(first_x);
         uy_ff <= DW'(second_y) - DW'(first_y);
         uz_ff <= DW'(second_z) - DW'(first_z);
         vx_ff <= DW'(third_x) - DW'(first_x);
         vy_ff <= DW'(third_y) - DW'(first_y);
         vz_ff <= DW'(third_z) - DW'(first_z);
         // stage 2: products
         pa_ff <= uy_ff * vz_ff;
         pb_ff <= uz_ff * vy_ff;
         pc_ff <= uz_ff * vx_ff;
         pd_ff <= ux_ff * vz_ff;
         pe_ff <= ux_ff * vy_ff;
         pf_ff <= uy_ff * vx_ff;
         dx_ff <= ux_ff * ux_ff;
         dy_ff <= uy_ff * uy_ff;
         dz_ff <= uz_ff * uz_ff;
         // stage 3: cross product magnitudes
         mag_ff   <= mag_in;
         dsum3_ff <= MW'(dx_ff) + MW'(dy_ff) + MW'(dz_ff);
         // stage 4: partial products of the squares
         for (int i = 0; i < 3; i++) begin
            hh_ff[i] <= mag_ff[i][MW-1:HW] * mag_ff[i][MW-1:HW];
            hl_ff[i] <= mag_ff[i][MW-1:HW] * mag_ff[i][HW-1:0];
            ll_ff[i] <= mag_ff[i][HW-1:0] * mag_ff[i][HW-1:0];
         end
         dsum4_ff <= dsum3_ff;
         // stage 5: squares
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= {hh_ff[i], {MW{1'b0}}}
                      + pdta_pkg::SQ_W'({hl_ff[i], {(HW+1){1'b0}}})
                      + pdta_pkg::SQ_W'(ll_ff[i]);
         end
         dsum5_ff <= dsum4_ff;
         // stage 6: radicand
         rad_ff <= rad_in;
      end
   end

   assign cell_out.valid = valid_ff[5];
   assign cell_out.rem   = '0;
   assign cell_out.root  = '0;
   assign cell_out.rad   = rad_ff;
endmodule
`default_nettype wire

// File: sv/pdta_sqrt_cell.sv
// ----------------------------------------------------------------------------
// pdta_sqrt_cell
// One root bit of the square root chain, two radicand bits per cell
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pdta_sqrt_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  pdta_pkg::sqrt_cell_type cell_in,
   output pdta_pkg::sqrt_cell_type cell_out
);
   localparam int RW = pdta_pkg::REM_W;
   localparam int TW = RW + 2;

   logic [TW-1:0] trial, test, diff;
   pdta_pkg::sqrt_cell_type cell_ff, cell_in_next;

   assign trial = {cell_in.rem, cell_in.rad[pdta_pkg::RAD_W-1 -: 2]};
   assign test  = TW'({cell_in.root, 2'b01});
   assign diff  = trial - test;

   always_comb begin
      cell_in_next.valid = cell_in.valid;
      cell_in_next.rad   = {cell_in.rad[pdta_pkg::RAD_W-3:0], 2'b00};
      if (trial >= test) begin
         cell_in_next.rem  = diff[RW-1:0];
         cell_in_next.root = {cell_in.root[pdta_pkg::ROOT_W-2:0], 1'b1};
      end else begin
         cell_in_next.rem  = trial[RW-1:0];
         cell_in_next.root = {cell_in.root[pdta_pkg::ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (en) begin
         cell_ff.valid <= cell_in_next.valid;
      end
      if (en) begin
         cell_ff.rem  <= cell_in_next.rem;
         cell_ff.root <= cell_in_next.root;
         cell_ff.rad  <= cell_in_next.rad;
      end
   end

   assign cell_out = cell_ff;
endmodule
`default_nettype wire

// File: sv/point_distance_triangle_area_3d.sv
// Pipeline: 6 arithmetic stages, then 26 root cells, from request to result.
// Throughput: one request per cycle; the whole pipeline stalls only while
// a finished result waits on rsp_ready.
// Reset: synchronous, clears all stage valid bits; no other state.
// ----------------------------------------------------------------------------
// point_distance_triangle_area_3d
// 3-D point distance or triangle area via a pipelined square root cell chain
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module point_distance_triangle_area_3d (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_ready,
   input  wire logic                                req_op,
   input  wire logic signed [pdta_pkg::COORD_W-1:0] req_first_x,
   input  wire logic signed [pdta_pkg::COORD_W-1:0] req_first_y,
   input  wire logic signed [pdta_pkg::COORD_W-1:0] req_first_z,
   input  wire logic signed [pdta_pkg::COORD_W-1:0] req_second_x,
   input  wire logic signed [pdta_pkg::COORD_W-1:0] req_second_y,
   input  wire logic signed [pdta_pkg::COORD_W-1:0] req_second_z,
   input  wire logic signed [pdta_pkg::COORD_W-1:0] req_third_x,
   input  wire logic signed [pdta_pkg::COORD_W-1:0] req_third_y,
   input  wire logic signed [pdta_pkg::COORD_W-1:0] req_third_z,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   output      logic [pdta_pkg::RESULT_W-1:0]       rsp_result_value
);
   logic en;
   pdta_pkg::sqrt_cell_type chain [pdta_pkg::N_CELLS+1];

   assign en        = !chain[pdta_pkg::N_CELLS].valid || rsp_ready;
   assign req_ready = en;

   pdta_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .op       (req_op),
      .first_x  (req_first_x),
      .first_y  (req_first_y),
      .first_z  (req_first_z),
      .second_x (req_second_x),
      .second_y (req_second_y),
      .second_z (req_second_z),
      .third_x  (req_third_x),
      .third_y  (req_third_y),
      .third_z  (req_third_z),
      .cell_out (chain[0])
   );

   for (genvar g = 0; g < pdta_pkg::N_CELLS; g++) begin : g_cell
      pdta_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .cell_in  (chain[g]),
         .cell_out (chain[g+1])
      );
   end

   assign rsp_valid        = chain[pdta_pkg::N_CELLS].valid;
   assign rsp_result_value = chain[pdta_pkg::N_CELLS].root[pdta_pkg::RESULT_W-1:0];
endmodule
`default_nettype wire
